// ===== sv/utf8_to_ucs2_decoder_defines.svh =====
// Shared assertion macros for the UTF-8 to UCS-2 decoder.
// They expect clk and rst (synchronous, active high) in the using module.
`ifndef UTF8_TO_UCS2_DECODER_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_DEFINES_SVH

// cons holds in the same cycle as ante
`define U2U_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/utf8dec_pkg.sv =====
package utf8dec_pkg;

  localparam logic [7:0] ASCII_MASK     = 8'h80;
  localparam logic [7:0] TWO_BYTE_MASK  = 8'h20;
  localparam logic [7:0] LEAD2_MASK     = 8'h1f;
  localparam logic [7:0] CONT_MASK      = 8'h3f;
  localparam logic [7:0] LEAD3_MASK     = 8'h0f;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] byte_count;
  } result_t;

endpackage

// ===== sv/utf8_to_ucs2_decoder.sv =====
// Channel  Handshake                    Payload
// in       in_valid / in_stall          in_byte
// out      out_valid / out_stall        code_unit, is_end, byte_count
// cfg      cfg_wr_en                    cfg_wr_data (capacity_bytes)
//
// One word per cycle sustained while out_stall is low; out_valid is a registered output.
// Input register -> decode with string state -> output register.
// A word with no result (lead, non-final continuation, overflow) leaves out_valid low.
// rst clears string state, both valids, and sets capacity to 256 bytes.
// out_stall holds the output register; the input register then fills and in_stall rises.
`include "utf8_to_ucs2_decoder_defines.svh"

module utf8_to_ucs2_decoder
  import utf8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        is_end,
  output logic [15:0] byte_count,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] capacity;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        s1_advance;
  logic        in_take;
  result_t     step_res;

  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_byte <= in_byte;
    end
  end

  utf8dec_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (s1_advance),
    .byte_in  (s1_byte),
    .capacity (capacity),
    .result   (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_advance && step_res.valid;
    end
    if (out_free && s1_advance && step_res.valid) begin
      code_unit  <= step_res.code_unit;
      is_end     <= step_res.is_end;
      byte_count <= step_res.byte_count;
    end
  end

  `U2U_ASSERT_SAME(a_stall_needs_word, in_stall, s1_valid && out_valid,
    "input stalled with room downstream")
  `U2U_ASSERT_SAME(a_end_zero_unit, out_valid && is_end, code_unit == 16'd0,
    "end word carries a code unit")
  `U2U_ASSERT_SAME(a_unit_no_count, out_valid && !is_end, byte_count == 16'd0,
    "code unit word carries a byte count")

endmodule

// ===== sv/utf8dec_core.sv =====
`include "utf8_to_ucs2_decoder_defines.svh"

module utf8dec_core
  import utf8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  logic [7:0]  byte_in,
  input  logic [15:0] capacity,
  output result_t     result
);

  logic [15:0] unit_count, unit_count_next;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [15:0] partial_code, partial_code_next;
  logic        capacity_reached, capacity_reached_next;

  logic [7:0]  cont_bits, lead2_bits, lead3_bits;
  logic [15:0] merged_code;
  logic [17:0] needed_bytes;
  logic        cap_fail;

  assign cont_bits  = byte_in & CONT_MASK;
  assign lead2_bits = byte_in & LEAD2_MASK;
  assign lead3_bits = byte_in & LEAD3_MASK;

  // first continuation of a three-byte sequence lands in bits 11:6
  assign merged_code = (bytes_pending == PEND_TWO)
                     ? (partial_code | {4'd0, cont_bits[5:0], 6'd0})
                     : (partial_code | {10'd0, cont_bits[5:0]});

  assign needed_bytes = {1'b0, unit_count, 1'b0} + 18'd2;
  assign cap_fail     = needed_bytes >= {2'd0, capacity};

  always_comb begin
    unit_count_next       = unit_count;
    bytes_pending_next    = bytes_pending;
    partial_code_next     = partial_code;
    capacity_reached_next = capacity_reached;
    result                = '0;

    if (byte_in == 8'd0) begin
      result.valid          = 1'b1;
      result.is_end         = 1'b1;
      result.byte_count     = {unit_count[14:0], 1'b0};
      unit_count_next       = '0;
      bytes_pending_next    = PEND_NONE;
      partial_code_next     = '0;
      capacity_reached_next = 1'b0;
    end else if (bytes_pending != PEND_NONE) begin
      partial_code_next  = merged_code;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == PEND_ONE) begin
        result.valid     = 1'b1;
        result.code_unit = merged_code;
        unit_count_next  = unit_count + 16'd1;
      end
    end else if (capacity_reached) begin
      // string overflowed: drop the rest
    end else if (cap_fail) begin
      capacity_reached_next = 1'b1;
    end else if ((byte_in & ASCII_MASK) == 8'd0) begin
      result.valid     = 1'b1;
      result.code_unit = {8'd0, byte_in};
      unit_count_next  = unit_count + 16'd1;
    end else if ((byte_in & TWO_BYTE_MASK) == 8'd0) begin
      partial_code_next  = {5'd0, lead2_bits[4:0], 6'd0};
      bytes_pending_next = PEND_ONE;
    end else begin
      partial_code_next  = {lead3_bits[3:0], 12'd0};
      bytes_pending_next = PEND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_count       <= '0;
      bytes_pending    <= PEND_NONE;
      partial_code     <= '0;
      capacity_reached <= 1'b0;
    end else if (step_en) begin
      unit_count       <= unit_count_next;
      bytes_pending    <= bytes_pending_next;
      partial_code     <= partial_code_next;
      capacity_reached <= capacity_reached_next;
    end
  end

  `U2U_ASSERT_SAME(a_pend_legal, 1'b1,
    bytes_pending == PEND_NONE || bytes_pending == PEND_ONE || bytes_pending == PEND_TWO,
    "pending count out of range")
  `U2U_ASSERT_NEXT(a_end_clears, step_en && byte_in == 8'd0,
    unit_count == 16'd0 && bytes_pending == PEND_NONE && !capacity_reached,
    "string state not cleared after terminator")
  `U2U_ASSERT_SAME(a_full_idle, capacity_reached, bytes_pending == PEND_NONE,
    "sequence pending after capacity ran out")

endmodule

// ===== dv/utf8_to_ucs2_decoder_test.sv =====
module utf8_to_ucs2_decoder_test;
  import utf8dec_pkg::*;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] byte_count;
  } ucs2_word_t;

  typedef logic [7:0] utf8_bytes_t [$];

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic        is_end;
  logic [15:0] byte_count;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // decoder state as predicted by the testbench
  logic [15:0] cap_bytes;
  logic [15:0] units_done;
  logic [1:0]  cont_left;
  logic [15:0] code_acc;
  logic        buffer_full;

  ucs2_word_t  ucs2_expected[$];
  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  bit          tx_pauses = 1'b0;
  bit          rx_pauses = 1'b0;

  utf8_to_ucs2_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .is_end      (is_end),
    .byte_count  (byte_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_string_state();
    units_done  = '0;
    cont_left   = PEND_NONE;
    code_acc    = '0;
    buffer_full = 1'b0;
  endfunction

  // Returns 1 when the byte produces an output word.
  function automatic bit decode_utf8_byte(input logic [7:0] b, output ucs2_word_t w);
    w = '0;
    if (b == 8'h00) begin
      w.is_end     = 1'b1;
      w.byte_count = {units_done[14:0], 1'b0};
      clear_string_state();
      return 1'b1;
    end
    if (cont_left != PEND_NONE) begin
      if (cont_left == PEND_TWO)
        code_acc = code_acc | ({8'h00, b & CONT_MASK} << 6);
      else
        code_acc = code_acc | {8'h00, b & CONT_MASK};
      cont_left = cont_left - 2'd1;
      if (cont_left == PEND_NONE) begin
        w.code_unit = code_acc;
        units_done  = units_done + 16'd1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (buffer_full)
      return 1'b0;
    // room check uses 17+ bits so 2*units+2 never wraps
    if (32'(units_done) * 2 + 2 >= 32'(cap_bytes)) begin
      buffer_full = 1'b1;
      return 1'b0;
    end
    if ((b & ASCII_MASK) == 8'h00) begin
      w.code_unit = {8'h00, b};
      units_done  = units_done + 16'd1;
      return 1'b1;
    end
    if ((b & TWO_BYTE_MASK) == 8'h00) begin
      code_acc  = {8'h00, b & LEAD2_MASK} << 6;
      cont_left = PEND_ONE;
    end else begin
      code_acc  = {8'h00, b & LEAD3_MASK} << 12;
      cont_left = PEND_TWO;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at output word %0d: %s", words_seen, msg);
  endtask

  always @(posedge clk) begin : check_output
    ucs2_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (ucs2_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected word unit=%h end=%b count=%0d",
                                  code_unit, is_end, byte_count));
      end else begin
        want = ucs2_expected.pop_front();
        if (code_unit !== want.code_unit)
          report_mismatch($sformatf("code_unit %h, expected %h", code_unit, want.code_unit));
        if (is_end !== want.is_end)
          report_mismatch($sformatf("is_end %b, expected %b", is_end, want.is_end));
        if (byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, expected %0d",
                                    byte_count, want.byte_count));
      end
      words_seen++;
    end
    if (stall_left != 0)
      stall_left--;
    else if (rx_pauses && $urandom_range(0, 6) == 0)
      stall_left = $urandom_range(1, 11);
    out_stall <= (stall_left != 0);
  end

  // Leaves in_valid high on return unless a random pause lowered it; anything that waits afterwards lowers it first.
  task automatic send_byte(input logic [7:0] b);
    ucs2_word_t w;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (decode_utf8_byte(b, w))
      ucs2_expected.push_back(w);
    bytes_sent++;
    if (tx_pauses && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_bytes(input utf8_bytes_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Sender holds off until every predicted word is out, then lets the pipe empty.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ucs2_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    drain_outputs();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cap_bytes = cap;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(8'($urandom_range(1, 127)));
      4, 5: begin
        send_byte(8'h80 | (8'($urandom) & 8'h5f));
        send_byte(8'h80 | (8'($urandom) & CONT_MASK));
      end
      6, 7: begin
        send_byte(8'ha0 | 8'($urandom));
        // continuation bits above six are don't-care; sometimes scramble them
        send_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                            : 8'h80 | (8'($urandom) & CONT_MASK));
        send_byte(8'h80 | (8'($urandom) & CONT_MASK));
      end
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic send_random_string();
    int unsigned nchars;
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
    repeat (nchars) send_random_char();
    // string sometimes cut off in the middle of a multi-byte sequence
    case ($urandom_range(0, 7))
      0: send_byte(8'hc0 | (8'($urandom) & LEAD2_MASK));
      1: send_byte(8'he0 | (8'($urandom) & LEAD3_MASK));
      2: begin
        send_byte(8'he0 | (8'($urandom) & LEAD3_MASK));
        send_byte(8'h80 | (8'($urandom) & CONT_MASK));
      end
      default: ;
    endcase
    send_byte(8'h00);
  endtask

  task automatic test_directed_bytes();
    // reset capacity of 256 is in effect here
    send_bytes('{8'h41, 8'h7f, 8'h01, 8'hc3, 8'ha9, 8'hdf, 8'hbf,
                 8'he2, 8'h82, 8'hac, 8'hef, 8'hbf, 8'hbf});
    // continuation bytes in lead position, then an all-ones sequence
    send_bytes('{8'h80, 8'h80, 8'ha0, 8'h80, 8'h80, 8'hff, 8'hff, 8'hff, 8'h00});
    // terminator in the middle of a three-byte sequence
    send_bytes('{8'he2, 8'h82, 8'h00});
  endtask

  task automatic test_capacity_edges();
    set_capacity(16'd0);
    send_bytes('{8'h41, 8'hc3, 8'ha9, 8'h00});
    set_capacity(16'd1);
    send_bytes('{8'h41, 8'h00});
    set_capacity(16'd2);
    send_bytes('{8'h41, 8'h00});
    set_capacity(16'd3);
    send_bytes('{8'h41, 8'h42, 8'h00});
    // once full, raising capacity mid-string does not reopen it
    set_capacity(16'd4);
    send_bytes('{8'h41, 8'h42});
    set_capacity(16'hffff);
    send_bytes('{8'h43, 8'he2, 8'h82, 8'hac, 8'h00});
    // a sequence already started completes after capacity drops
    set_capacity(16'd256);
    send_bytes('{8'h41, 8'hc3});
    set_capacity(16'd0);
    send_bytes('{8'ha9, 8'h41, 8'h00});
    set_capacity(16'hffff);
    send_bytes('{8'hc3, 8'h00});
  endtask

  task automatic test_random_strings();
    logic [15:0] cap;
    while (bytes_sent < 1650) begin
      case ($urandom_range(0, 5))
        0: cap = 16'($urandom_range(0, 3));
        1: cap = 16'hffff;
        2: cap = 16'($urandom);
        3, 4: cap = 16'($urandom_range(4, 60));
        default: cap = 16'd256;
      endcase
      set_capacity(cap);
      repeat ($urandom_range(1, 4)) begin
        tx_pauses = ($urandom_range(0, 3) != 0);
        rx_pauses = ($urandom_range(0, 3) != 0);
        send_random_string();
      end
    end
  endtask

  task automatic test_back_to_back();
    tx_pauses = 1'b0;
    rx_pauses = 1'b0;
    set_capacity(16'($urandom_range(200, 65535)));
    while (bytes_sent < 1950) send_random_string();
  endtask

  initial begin
    int unsigned waited;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_byte     <= 8'h00;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 16'h0000;
    cap_bytes = CAPACITY_RESET;
    clear_string_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_bytes();
    test_capacity_edges();
    test_random_strings();
    test_back_to_back();

    in_valid <= 1'b0;
    waited = 0;
    while (ucs2_expected.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (ucs2_expected.size() != 0)
      report_mismatch($sformatf("%0d expected words never came out", ucs2_expected.size()));
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
